// File: rtl/swerve_drive_inverse_kinematics_macros.svh
// assertion macros for the top-level module
`ifndef SWERVE_DRIVE_INVERSE_KINEMATICS_MACROS_SVH
`define SWERVE_DRIVE_INVERSE_KINEMATICS_MACROS_SVH

// same-cycle implication
`define SDIK_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define SDIK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/sdik_pkg.sv
`timescale 1ns / 1ps
package sdik_pkg;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int RADIUS_W   = 15;
  localparam int OFFSET_W   = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CORNER_W   = 19;
  localparam int SQ_W       = 37;
  localparam int RAD_W      = 52;
  localparam int ROOT_W     = 26;
  localparam int DEN_W      = 47;
  localparam int DIV_W      = 64;
  localparam int QUO_W      = 16;
  localparam int Z_W        = 34;
  localparam int XY_W       = 34;
  localparam int SPEED_LAT  = 47;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [33:0] PI_Q30 = 34'd3373259426;
  localparam logic signed [17:0] ANGLE_LIMIT = 18'sd25736;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd205;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 15'd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS       = 2'd0,
    REG_WHEEL_OFFSET = 2'd1
  } cfg_reg_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      0:  v = 34'sh03243F6A8;
      1:  v = 34'sh01DAC6705;
      2:  v = 34'sh00FADBAFC;
      3:  v = 34'sh007F56EA6;
      4:  v = 34'sh003FEAB76;
      5:  v = 34'sh001FFD55B;
      6:  v = 34'sh000FFFAAA;
      7:  v = 34'sh0007FFF55;
      8:  v = 34'sh0003FFFEA;
      9:  v = 34'sh0001FFFFD;
      10: v = 34'sh0000FFFFF;
      11: v = 34'sh00007FFFF;
      12: v = 34'sh00003FFFF;
      13: v = 34'sh00001FFFF;
      14: v = 34'sh00000FFFF;
      15: v = 34'sh000007FFF;
      16: v = 34'sh000003FFF;
      17: v = 34'sh000001FFF;
      18: v = 34'sh000000FFF;
      19: v = 34'sh0000007FF;
      20: v = 34'sh0000003FF;
      21: v = 34'sh0000001FF;
      22: v = 34'sh0000000FF;
      23: v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/sdik_cmd_if.sv
`timescale 1ns / 1ps
interface sdik_cmd_if;
  logic valid;
  logic ready;
  logic signed [sdik_pkg::IN_W-1:0] forward_speed;
  logic signed [sdik_pkg::IN_W-1:0] sideways_speed;
  logic signed [sdik_pkg::IN_W-1:0] turn_rate;
  modport source(output valid, forward_speed, sideways_speed, turn_rate, input ready);
  modport sink(input valid, forward_speed, sideways_speed, turn_rate, output ready);
endinterface

// File: rtl/sdik_wheel_if.sv
`timescale 1ns / 1ps
interface sdik_wheel_if;
  logic valid;
  logic ready;
  logic signed [sdik_pkg::OUT_W-1:0] front_left_speed;
  logic signed [sdik_pkg::OUT_W-1:0] front_right_speed;
  logic signed [sdik_pkg::OUT_W-1:0] rear_left_speed;
  logic signed [sdik_pkg::OUT_W-1:0] rear_right_speed;
  logic signed [sdik_pkg::OUT_W-1:0] front_left_angle;
  logic signed [sdik_pkg::OUT_W-1:0] front_right_angle;
  logic signed [sdik_pkg::OUT_W-1:0] rear_left_angle;
  logic signed [sdik_pkg::OUT_W-1:0] rear_right_angle;
  modport source(output valid, front_left_speed, front_right_speed, rear_left_speed,
                 rear_right_speed, front_left_angle, front_right_angle, rear_left_angle,
                 rear_right_angle, input ready);
  modport sink(input valid, front_left_speed, front_right_speed, rear_left_speed,
               rear_right_speed, front_left_angle, front_right_angle, rear_left_angle,
               rear_right_angle, output ready);
endinterface

// File: rtl/sdik_cfg_if.sv
`timescale 1ns / 1ps
interface sdik_cfg_if;
  logic valid;
  logic ready;
  logic [sdik_pkg::CFG_IDX_W-1:0] index;
  logic [sdik_pkg::RADIUS_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/swerve_drive_inverse_kinematics.sv
// channel  dir  fields
// cmd      in   forward_speed, sideways_speed, turn_rate
// wheel    out  four wheel speeds, four steering angles
// cfg      in   index, data (radius, wheel_offset)
// one item per cycle unless a result is stalled
// each speed lane has a 26-stage square root and a 16-stage divider per wheel
// synchronous reset clears valid bits and loads register defaults
// a stalled result freezes the whole pipeline; cfg is always ready
`timescale 1ns / 1ps
`include "swerve_drive_inverse_kinematics_macros.svh"
module swerve_drive_inverse_kinematics #(
  parameter int CORDIC_STAGES = sdik_pkg::CORDIC_STAGES_DEF
) (
  input logic clk,
  input logic rst,
  sdik_cmd_if.sink cmd,
  sdik_wheel_if.source wheel,
  sdik_cfg_if.sink cfg
);
  localparam int CW = sdik_pkg::CORNER_W;
  localparam int TOTAL = 2 + sdik_pkg::SPEED_LAT;

  logic [sdik_pkg::RADIUS_W-1:0] radius;
  logic [sdik_pkg::OFFSET_W-1:0] wheel_offset;
  logic [sdik_pkg::DEN_W-1:0] den;
  logic [TOTAL-1:0] vld;
  logic en;
  logic radius_zero;
  logic angle_ok;
  logic signed [sdik_pkg::IN_W-1:0] x1, y1;
  logic signed [31:0] prod;
  logic signed [31:0] hr;
  logic signed [CW-1:0] h, xe, ye;
  logic signed [CW-1:0] ca, cb, cc, cd;

  assign en = !vld[TOTAL-1] || wheel.ready;
  assign cmd.ready = en;
  assign cfg.ready = 1'b1;
  assign wheel.valid = vld[TOTAL-1];
  assign radius_zero = (radius == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= sdik_pkg::RADIUS_RESET;
      wheel_offset <= sdik_pkg::OFFSET_RESET;
    end else if (cfg.valid) begin
      unique case (sdik_pkg::cfg_reg_t'(cfg.index))
        sdik_pkg::REG_RADIUS:       radius <= cfg.data;
        sdik_pkg::REG_WHEEL_OFFSET: wheel_offset <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    den <= sdik_pkg::DEN_W'(sdik_pkg::PI_Q30) * sdik_pkg::DEN_W'(radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], cmd.valid};
    end
  end

  // turn product, then corner sums
  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= cmd.forward_speed;
      y1 <= cmd.sideways_speed;
      prod <= cmd.turn_rate * $signed({1'b0, wheel_offset});
    end
  end

  assign hr = (prod + 32'sd4096) >>> 13;
  assign h  = hr[CW-1:0];
  assign xe = CW'(x1);
  assign ye = CW'(y1);

  always_ff @(posedge clk) begin
    if (en) begin
      ca <= -ye - h;
      cb <= -ye + h;
      cc <= xe - h;
      cd <= xe + h;
    end
  end

  sdik_speed_lane u_spd_fl (.clk, .en, .p(cb), .q(cd), .den,
    .radius_zero(radius_zero), .negate(1'b1), .speed(wheel.front_left_speed));
  sdik_speed_lane u_spd_fr (.clk, .en, .p(cb), .q(cc), .den,
    .radius_zero(radius_zero), .negate(1'b0), .speed(wheel.front_right_speed));
  sdik_speed_lane u_spd_rl (.clk, .en, .p(ca), .q(cd), .den,
    .radius_zero(radius_zero), .negate(1'b1), .speed(wheel.rear_left_speed));
  sdik_speed_lane u_spd_rr (.clk, .en, .p(ca), .q(cc), .den,
    .radius_zero(radius_zero), .negate(1'b0), .speed(wheel.rear_right_speed));

  sdik_angle_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_ang_fl (.clk, .en, .p(cb), .q(cd),
    .angle(wheel.front_left_angle));
  sdik_angle_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_ang_fr (.clk, .en, .p(cb), .q(cc),
    .angle(wheel.front_right_angle));
  sdik_angle_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_ang_rl (.clk, .en, .p(ca), .q(cd),
    .angle(wheel.rear_left_angle));
  sdik_angle_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_ang_rr (.clk, .en, .p(ca), .q(cc),
    .angle(wheel.rear_right_angle));

  assign angle_ok = (wheel.front_left_angle <= sdik_pkg::ANGLE_LIMIT) &&
                    (wheel.front_left_angle >= -sdik_pkg::ANGLE_LIMIT);

  `SDIK_ASSERT_IMPL(a_zero_radius, clk, rst, wheel.valid && radius_zero, wheel.front_left_speed == 0)
  `SDIK_ASSERT_IMPL(a_left_sign, clk, rst, wheel.valid, wheel.front_left_speed <= 0)
  `SDIK_ASSERT_IMPL(a_right_sign, clk, rst, wheel.valid, wheel.front_right_speed >= 0)
  `SDIK_ASSERT_IMPL(a_angle_range, clk, rst, wheel.valid, angle_ok)
  `SDIK_ASSERT_NEXT(a_stall_hold, clk, rst, !en, $stable(vld))
endmodule

// File: rtl/sdik_speed_lane.sv
`timescale 1ns / 1ps
module sdik_speed_lane (
  input  logic clk,
  input  logic en,
  input  logic signed [sdik_pkg::CORNER_W-1:0] p,
  input  logic signed [sdik_pkg::CORNER_W-1:0] q,
  input  logic [sdik_pkg::DEN_W-1:0] den,
  input  logic radius_zero,
  input  logic negate,
  output logic signed [sdik_pkg::OUT_W-1:0] speed
);
  localparam int CW = sdik_pkg::CORNER_W;
  localparam int RW = sdik_pkg::RAD_W;
  localparam int DW = sdik_pkg::DIV_W;
  localparam int QW = sdik_pkg::QUO_W;
  localparam int NS = sdik_pkg::ROOT_W;

  logic signed [2*CW-1:0] p_ext, q_ext;
  logic [sdik_pkg::SQ_W-1:0] psq, qsq;
  logic [RW-1:0] n_s [0:NS];
  logic [RW-1:0] r_s [0:NS];
  logic [DW-1:0] den_ext;
  logic [DW-1:0] numer;
  logic [DW-1:0] rem_s [0:QW];
  logic [QW-1:0] quo_s [0:QW];
  logic ovf_s [0:QW];
  logic [QW:0] mag;

  assign p_ext = (2*CW)'(p);
  assign q_ext = (2*CW)'(q);
  assign den_ext = DW'(den);

  // squares, then radicand
  always_ff @(posedge clk) begin
    if (en) begin
      psq <= sdik_pkg::SQ_W'($unsigned(p_ext * p_ext));
      qsq <= sdik_pkg::SQ_W'($unsigned(q_ext * q_ext));
      n_s[0] <= RW'({1'b0, psq} + {1'b0, qsq}) << 16;
      r_s[0] <= '0;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2*k);
    logic [RW:0] trial;
    assign trial = {1'b0, r_s[k]} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, n_s[k]} >= trial) begin
          n_s[k+1] <= n_s[k] - trial[RW-1:0];
          r_s[k+1] <= (r_s[k] >> 1) + BIT;
        end else begin
          n_s[k+1] <= n_s[k];
          r_s[k+1] <= r_s[k] >> 1;
        end
      end
    end
  end

  // rounded dividend and overflow test
  always_ff @(posedge clk) begin
    if (en) begin
      numer <= (DW'(r_s[NS][sdik_pkg::ROOT_W-1:0]) << 30) + (den_ext >> 1);
      rem_s[0] <= numer;
      quo_s[0] <= '0;
      ovf_s[0] <= numer >= (den_ext << QW);
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [DW-1:0] dsh;
    assign dsh = den_ext << B;
    always_ff @(posedge clk) begin
      if (en) begin
        ovf_s[j+1] <= ovf_s[j];
        if (rem_s[j] >= dsh) begin
          rem_s[j+1] <= rem_s[j] - dsh;
          quo_s[j+1] <= quo_s[j] | (QW'(1) << B);
        end else begin
          rem_s[j+1] <= rem_s[j];
          quo_s[j+1] <= quo_s[j];
        end
      end
    end
  end

  always_comb begin
    if (radius_zero) begin
      mag = '0;
    end else if (ovf_s[QW]) begin
      mag = {1'b0, {QW{1'b1}}};
    end else begin
      mag = {1'b0, quo_s[QW]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (negate) begin
        speed <= (mag > 17'd32768) ? -16'sd32768 : 16'($signed(-$signed({1'b0, mag})));
      end else begin
        speed <= (mag > 17'd32767) ? 16'sd32767 : 16'(mag);
      end
    end
  end
endmodule

// File: rtl/sdik_angle_lane.sv
`timescale 1ns / 1ps
module sdik_angle_lane #(
  parameter int CORDIC_STAGES = sdik_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic en,
  input  logic signed [sdik_pkg::CORNER_W-1:0] p,
  input  logic signed [sdik_pkg::CORNER_W-1:0] q,
  output logic signed [sdik_pkg::OUT_W-1:0] angle
);
  localparam int CW = sdik_pkg::CORNER_W;
  localparam int XW = sdik_pkg::XY_W;
  localparam int ZW = sdik_pkg::Z_W;
  localparam int DELAY = sdik_pkg::SPEED_LAT - CORDIC_STAGES - 2;
  localparam logic signed [ZW-1:0] PI_Z = ZW'(sdik_pkg::PI_Q30);
  localparam logic signed [ZW-1:0] HALF = ZW'(1) << 16;

  logic signed [XW-1:0] xs, ys;
  logic signed [XW-1:0] x_s [0:CORDIC_STAGES];
  logic signed [XW-1:0] y_s [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_s [0:CORDIC_STAGES];
  logic zf_s [0:CORDIC_STAGES];
  logic signed [ZW-1:0] zr;
  logic signed [ZW-18:0] zq;
  logic signed [ZW-17:0] neg;
  logic signed [sdik_pkg::OUT_W-1:0] dly [0:DELAY];

  assign xs = {{(XW-CW-12){q[CW-1]}}, q, 12'b0};
  assign ys = {{(XW-CW-12){p[CW-1]}}, p, 12'b0};

  // half-plane fold
  always_ff @(posedge clk) begin
    if (en) begin
      zf_s[0] <= (p == '0) && (q == '0);
      if (q < 0) begin
        x_s[0] <= -xs;
        y_s[0] <= -ys;
        z_s[0] <= (p >= 0) ? PI_Z : -PI_Z;
      end else begin
        x_s[0] <= xs;
        y_s[0] <= ys;
        z_s[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = sdik_pkg::atan_q30(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zf_s[i+1] <= zf_s[i];
        if (y_s[i] >= 0) begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + ATAN;
        end else begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - ATAN;
        end
      end
    end
  end

  assign zr  = z_s[CORDIC_STAGES] + HALF;
  assign zq  = zr[ZW-1:17];
  assign neg = -{zq[ZW-18], zq};

  always_ff @(posedge clk) begin
    if (en) begin
      if (zf_s[CORDIC_STAGES]) begin
        dly[0] <= '0;
      end else if (neg > sdik_pkg::ANGLE_LIMIT) begin
        dly[0] <= 16'(sdik_pkg::ANGLE_LIMIT);
      end else if (neg < -sdik_pkg::ANGLE_LIMIT) begin
        dly[0] <= 16'(-sdik_pkg::ANGLE_LIMIT);
      end else begin
        dly[0] <= 16'(neg);
      end
    end
  end

  // align with the speed path
  for (genvar d = 0; d < DELAY; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dly[d+1] <= dly[d];
      end
    end
  end

  assign angle = dly[DELAY];
endmodule
